// ===== src/qte_pkg.sv =====
package qte_pkg;

    localparam int NUM_TERMS = 6;
    localparam int NUM_AXES  = 3;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_EVAL  = 2'd1;
    localparam logic [1:0] REQ_CHECK = 2'd2;

    localparam logic [1:0] CFG_HORIZON = 2'd0;
    localparam logic [1:0] CFG_VEL     = 2'd1;
    localparam logic [1:0] CFG_ACCEL   = 2'd2;
    localparam logic [1:0] CFG_JERK    = 2'd3;

    localparam logic [23:0] HORIZON_RST = 24'd2097152;
    localparam logic [31:0] VEL_RST     = 32'd655360;
    localparam logic [31:0] ACCEL_RST   = 32'd655360;
    localparam logic [31:0] JERK_RST    = 32'd3932160;

    typedef logic signed [47:0] t_val48;

    // i! / (i-k)!, zero when k > i
    function automatic logic [6:0] falling_fac(input logic [3:0] i, input logic [2:0] k);
        logic [6:0] r;
        r = 7'd0;
        case ({i, k})
            {4'd0, 3'd0}, {4'd1, 3'd0}, {4'd2, 3'd0}, {4'd3, 3'd0},
            {4'd4, 3'd0}, {4'd5, 3'd0}, {4'd1, 3'd1}: r = 7'd1;
            {4'd2, 3'd1}, {4'd2, 3'd2}: r = 7'd2;
            {4'd3, 3'd1}: r = 7'd3;
            {4'd4, 3'd1}: r = 7'd4;
            {4'd5, 3'd1}: r = 7'd5;
            {4'd3, 3'd2}, {4'd3, 3'd3}: r = 7'd6;
            {4'd4, 3'd2}: r = 7'd12;
            {4'd5, 3'd2}: r = 7'd20;
            {4'd4, 3'd3}, {4'd4, 3'd4}: r = 7'd24;
            {4'd5, 3'd3}: r = 7'd60;
            {4'd5, 3'd4}, {4'd5, 3'd5}: r = 7'd120;
            default: r = 7'd0;
        endcase
        return r;
    endfunction

    // C(i,j) * 10 / C(5,j)
    function automatic logic [3:0] cp_weight(input logic [2:0] i, input logic [2:0] j);
        logic [3:0] r;
        r = 4'd0;
        if (j <= i) begin
            if (j == 3'd0 || i == 3'd5) begin
                r = 4'd10;
            end else begin
                case ({i, j})
                    {3'd1, 3'd1}: r = 4'd2;
                    {3'd2, 3'd1}: r = 4'd4;
                    {3'd2, 3'd2}: r = 4'd1;
                    {3'd3, 3'd1}: r = 4'd6;
                    {3'd3, 3'd2}: r = 4'd3;
                    {3'd3, 3'd3}: r = 4'd1;
                    {3'd4, 3'd1}: r = 4'd8;
                    {3'd4, 3'd2}: r = 4'd6;
                    {3'd4, 3'd3}: r = 4'd4;
                    {3'd4, 3'd4}: r = 4'd2;
                    default: r = 4'd0;
                endcase
            end
        end
        return r;
    endfunction

endpackage

// ===== src/quintic_trajectory_evaluator_unit.sv =====
// Quintic trajectory evaluator. A start is taken when i_start is high and o_busy is low;
// each item gives one result on o_done for a single cycle, which the receiver must take.
// A load (or an unused request) answers in the next cycle and leaves o_busy low. An
// evaluate runs Horner's rule on one shared 24x24 multiplier; each term passes through
// S_RD, S_TERM, S_MHI, S_MLO and S_MUPD. A feasibility check with an order outside 1..3
// goes straight to S_FIN. The coefficient memory has one write port and one registered
// read port.
module quintic_trajectory_evaluator_unit (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    output logic                    o_busy,
    input  logic [1:0]              i_req_type,
    input  logic [1:0]              i_axis_sel,
    input  logic [2:0]              i_term_index,
    input  logic signed [31:0]      i_coef_value,
    input  logic [23:0]             i_sample_time,
    input  logic [2:0]              i_order_sel,
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_index,
    input  logic [31:0]             i_cfg_data,
    output logic                    o_done,
    output qte_pkg::t_val48         o_x_value,
    output qte_pkg::t_val48         o_y_value,
    output qte_pkg::t_val48         o_z_value,
    output logic                    o_feasible,
    output logic                    o_saturated
);
    import qte_pkg::*;

    localparam int MEM_DEPTH = NUM_AXES * NUM_TERMS;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_TERM, S_CLD, S_MHI, S_MLO, S_MUPD, S_SACC, S_CMP, S_FIN
    } t_state;

    t_state              r_state;
    logic [23:0]         r_horizon;
    logic [31:0]         r_vel, r_accel, r_jerk;
    logic [31:0]         r_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] r_vld;
    logic [31:0]         r_rd_data;
    logic                r_rd_vld;
    logic [3:0]          r_rd_term;
    logic                r_eval;
    logic [2:0]          r_k, r_kstop, r_i, r_j, r_p;
    logic [1:0]          r_axis;
    logic [23:0]         r_tm;
    logic [35:0]         r_bound;
    logic signed [40:0]  r_term;
    t_val48              r_acc;
    logic [47:0]         r_phi, r_plo;
    logic signed [55:0]  r_s [NUM_TERMS];
    t_val48              r_val [NUM_AXES];
    logic                r_ok, r_clip, r_done, r_feas, r_sat;

    logic                accept;
    logic [3:0]          rd_term;
    logic [4:0]          rd_addr, wr_addr;
    logic [6:0]          fac;
    logic [31:0]         coef;
    logic                neg;
    logic [47:0]         mag;
    logic [23:0]         mul_a;
    logic [47:0]         mul_p;
    logic [47:0]         lo_rnd;
    logic [52:0]         rmag;
    logic signed [55:0]  mres, addend, sum;
    t_val48              n_acc;
    logic                n_clip;
    logic signed [55:0]  sprod;
    logic signed [55:0]  bnd;
    logic [31:0]         lim;

    assign accept  = i_start && (r_state == S_IDLE);
    assign o_busy  = (r_state != S_IDLE);
    assign wr_addr = 5'(i_axis_sel) * 5'd6 + 5'(i_term_index);
    assign rd_term = r_eval ? {1'b0, r_i} : ({1'b0, r_j} + {1'b0, r_k});
    assign rd_addr = 5'(r_axis) * 5'd6 + 5'(rd_term[2:0]);

    assign fac  = falling_fac(r_rd_term, r_k);
    assign coef = r_rd_vld ? r_rd_data : 32'd0;

    assign neg    = r_acc[47];
    assign mag    = neg ? 48'(-r_acc) : 48'(r_acc);
    assign mul_a  = (r_state == S_MHI) ? mag[47:24] : mag[23:0];
    assign mul_p  = mul_a * r_tm;
    assign lo_rnd = (r_plo + 48'd524288) >> 20;
    assign rmag   = {1'b0, r_phi, 4'b0} + 53'(lo_rnd);
    assign mres   = neg ? -signed'({3'b0, rmag}) : signed'({3'b0, rmag});
    assign addend = r_eval ? 56'(r_term) : 56'sd0;
    assign sum    = addend + mres;

    always_comb begin
        n_clip = 1'b0;
        n_acc  = sum[47:0];
        if (sum[55:47] != {9{sum[47]}}) begin
            n_clip = 1'b1;
            n_acc  = sum[55] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end
    end

    assign sprod = signed'({1'b0, cp_weight(r_i, r_j)}) * r_acc;
    assign bnd   = signed'({20'd0, r_bound});

    always_comb begin
        case (i_order_sel)
            3'd1:    lim = r_vel;
            3'd2:    lim = r_accel;
            default: lim = r_jerk;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_req_type == REQ_LOAD && i_axis_sel < 2'(NUM_AXES)
                && i_term_index < 3'(NUM_TERMS)) begin
            r_mem[wr_addr] <= i_coef_value;
        end
        if (r_state == S_RD) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_horizon <= HORIZON_RST;
            r_vel     <= VEL_RST;
            r_accel   <= ACCEL_RST;
            r_jerk    <= JERK_RST;
            r_vld     <= '0;
            r_done    <= 1'b0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_done <= (r_state == S_FIN)
                || (accept && i_req_type != REQ_EVAL && i_req_type != REQ_CHECK);
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_HORIZON: r_horizon <= i_cfg_data[23:0];
                    CFG_VEL:     r_vel     <= i_cfg_data;
                    CFG_ACCEL:   r_accel   <= i_cfg_data;
                    CFG_JERK:    r_jerk    <= i_cfg_data;
                    default:     ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_k      <= i_order_sel;
                        r_kstop  <= (i_order_sel > 3'd5) ? 3'd5 : i_order_sel;
                        r_axis   <= 2'd0;
                        r_i      <= 3'd5;
                        r_j      <= 3'd0;
                        r_acc    <= '0;
                        r_clip   <= 1'b0;
                        r_ok     <= (i_order_sel >= 3'd1 && i_order_sel <= 3'd3);
                        r_eval   <= (i_req_type == REQ_EVAL);
                        r_bound  <= {lim, 3'b0} + {3'b0, lim, 1'b0};
                        r_val[0] <= '0;
                        r_val[1] <= '0;
                        r_val[2] <= '0;
                        r_feas   <= 1'b0;
                        r_sat    <= 1'b0;
                        if (i_req_type == REQ_EVAL) begin
                            r_tm    <= (i_sample_time > r_horizon) ? r_horizon : i_sample_time;
                            r_state <= S_RD;
                        end else if (i_req_type == REQ_CHECK) begin
                            r_tm <= r_horizon;
                            if (i_order_sel >= 3'd1 && i_order_sel <= 3'd3) begin
                                r_state <= S_RD;
                            end else begin
                                r_state <= S_FIN;
                            end
                        end else begin
                            if (i_req_type == REQ_LOAD && i_axis_sel < 2'(NUM_AXES)
                                    && i_term_index < 3'(NUM_TERMS)) begin
                                r_vld[wr_addr] <= 1'b1;
                            end
                        end
                    end
                end
                S_RD: begin
                    r_rd_term <= rd_term;
                    r_rd_vld  <= (rd_term < 4'(NUM_TERMS)) && r_vld[rd_addr];
                    r_state   <= S_TERM;
                end
                S_TERM: begin
                    r_term  <= signed'({1'b0, fac}) * signed'(coef);
                    r_state <= r_eval ? S_MHI : S_CLD;
                end
                S_CLD: begin
                    r_acc <= 48'(r_term);
                    r_p   <= 3'd0;
                    if (r_j == 3'd0) begin
                        for (int n = 0; n < NUM_TERMS; n++) begin
                            r_s[n] <= '0;
                        end
                        r_i     <= 3'd0;
                        r_state <= S_SACC;
                    end else begin
                        r_state <= S_MHI;
                    end
                end
                S_MHI: begin
                    r_phi   <= mul_p;
                    r_state <= S_MLO;
                end
                S_MLO: begin
                    r_plo   <= mul_p;
                    r_state <= S_MUPD;
                end
                S_MUPD: begin
                    if (r_eval) begin
                        r_clip <= r_clip | n_clip;
                        if (r_i == r_kstop) begin
                            r_val[r_axis] <= n_acc;
                            r_acc         <= '0;
                            r_i           <= 3'd5;
                            if (r_axis == 2'(NUM_AXES - 1)) begin
                                r_state <= S_FIN;
                            end else begin
                                r_axis  <= r_axis + 2'd1;
                                r_state <= S_RD;
                            end
                        end else begin
                            r_acc   <= n_acc;
                            r_i     <= r_i - 3'd1;
                            r_state <= S_RD;
                        end
                    end else begin
                        r_acc <= n_acc;
                        r_p   <= r_p + 3'd1;
                        if (r_p + 3'd1 < r_j) begin
                            r_state <= S_MHI;
                        end else begin
                            r_i     <= r_j;
                            r_state <= S_SACC;
                        end
                    end
                end
                S_SACC: begin
                    r_s[r_i] <= r_s[r_i] + sprod;
                    if (r_i == 3'(NUM_TERMS - 1)) begin
                        if (r_j == 3'(NUM_TERMS - 1)) begin
                            r_i     <= 3'd0;
                            r_state <= S_CMP;
                        end else begin
                            r_j     <= r_j + 3'd1;
                            r_state <= S_RD;
                        end
                    end else begin
                        r_i <= r_i + 3'd1;
                    end
                end
                S_CMP: begin
                    if (r_s[r_i] > bnd || r_s[r_i] < -bnd) begin
                        r_ok <= 1'b0;
                    end
                    if (r_i == 3'(NUM_TERMS - 1)) begin
                        if (r_axis == 2'(NUM_AXES - 1)) begin
                            r_state <= S_FIN;
                        end else begin
                            r_axis  <= r_axis + 2'd1;
                            r_j     <= 3'd0;
                            r_state <= S_RD;
                        end
                    end else begin
                        r_i <= r_i + 3'd1;
                    end
                end
                S_FIN: begin
                    r_feas  <= r_eval ? 1'b0 : r_ok;
                    r_sat   <= r_eval ? r_clip : 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done      = r_done;
    assign o_x_value   = r_val[0];
    assign o_y_value   = r_val[1];
    assign o_z_value   = r_val[2];
    assign o_feasible  = r_feas;
    assign o_saturated = r_sat;

endmodule

// ===== src/qte_checker.sv =====
module qte_checker (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic                    o_busy,
    input  logic [1:0]              i_req_type,
    input  logic                    o_done,
    input  qte_pkg::t_val48         o_x_value,
    input  qte_pkg::t_val48         o_y_value,
    input  qte_pkg::t_val48         o_z_value,
    input  logic                    o_feasible,
    input  logic                    o_saturated
);
    import qte_pkg::*;

    a_load_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_req_type == REQ_LOAD) |=> (o_done && !o_busy))
        else $error("load transfer without result in next cycle");

    a_work_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_req_type == REQ_EVAL || i_req_type == REQ_CHECK))
            |=> (o_busy && !o_done))
        else $error("evaluate or check transfer did not hold busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result while busy");

    a_feas_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_feasible) |-> (o_x_value == '0 && o_y_value == '0
            && o_z_value == '0 && !o_saturated))
        else $error("feasible result carries values");

endmodule

bind quintic_trajectory_evaluator_unit qte_checker u_qte_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .i_req_type  (i_req_type),
    .o_done      (o_done),
    .o_x_value   (o_x_value),
    .o_y_value   (o_y_value),
    .o_z_value   (o_z_value),
    .o_feasible  (o_feasible),
    .o_saturated (o_saturated)
);
